### rtl/stt_pkg.sv
// Shared types and constants of the source text tokenizer.
package stt_pkg;

	// Result queue depth; the scanner needs room for two results per byte
	localparam int STT_QUEUE_DEPTH = 4;
	localparam int STT_DEFAULT_POSITION_BITS = 32;
	localparam int STT_DEFAULT_LENGTH_BITS = 16;

	// Token kinds
	localparam logic [4:0] KIND_EOF     = 5'd0;
	localparam logic [4:0] KIND_PUNCT0  = 5'd1;
	localparam logic [4:0] KIND_OPER0   = 5'd10;
	localparam logic [4:0] KIND_INT     = 5'd28;
	localparam logic [4:0] KIND_IDENT   = 5'd29;
	localparam logic [4:0] KIND_UNKNOWN = 5'd30;

	// One result item as it leaves the scanner
	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] position;
		logic [31:0] line;
		logic [31:0] column;
		logic [15:0] length;
		logic [63:0] value;
		logic        bad;
		logic        last;
	} stt_result_t;

	// Scanner status toward the top level
	typedef struct packed {
		logic       ended;
		logic [1:0] count;
	} stt_scan_status_t;

endpackage

### rtl/stt_scan.sv
// Scanner state and per-byte token logic of the source text tokenizer.
module stt_scan
	import stt_pkg::*;
#(
	parameter int POSITION_BITS = STT_DEFAULT_POSITION_BITS,
	parameter int LENGTH_BITS   = STT_DEFAULT_LENGTH_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       byte_in,
	input  logic             eos_in,
	output stt_result_t      res0,
	output stt_result_t      res1,
	output stt_scan_status_t status
);

	localparam int PB = POSITION_BITS;
	localparam int LB = LENGTH_BITS;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_B_LO  = 8'h62;
	localparam logic [7:0] CH_B_UP  = 8'h42;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_HEX = 2'd1;
	localparam logic [1:0] BASE_BIN = 2'd2;

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_OPER  = 3'd1,
		M_ZERO  = 3'd2,
		M_NUM   = 3'd3,
		M_IDENT = 3'd4
	} mode_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	// Digit worth; 16 marks a byte that is no digit
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [4:0] d;
		d = 5'd16;
		if (is_digit(c)) d = 5'(c - 8'h30);
		else if ((c >= 8'h41) && (c <= 8'h46)) d = 5'(c - 8'h41 + 8'd10);
		else if ((c >= 8'h61) && (c <= 8'h66)) d = 5'(c - 8'h61 + 8'd10);
		return d;
	endfunction

	// Punctuation kind, zero when the byte is none
	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			8'h28:   k = KIND_PUNCT0;
			8'h29:   k = KIND_PUNCT0 + 5'd1;
			8'h7B:   k = KIND_PUNCT0 + 5'd2;
			8'h7D:   k = KIND_PUNCT0 + 5'd3;
			8'h5B:   k = KIND_PUNCT0 + 5'd4;
			8'h5D:   k = KIND_PUNCT0 + 5'd5;
			8'h3A:   k = KIND_PUNCT0 + 5'd6;
			8'h3B:   k = KIND_PUNCT0 + 5'd7;
			8'h2C:   k = KIND_PUNCT0 + 5'd8;
			default: k = 5'd0;
		endcase
		return k;
	endfunction

	// Operator kind without the '=' suffix, zero when the byte is none
	function automatic logic [4:0] oper_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			8'h2B:   k = KIND_OPER0;
			8'h2D:   k = KIND_OPER0 + 5'd2;
			8'h2A:   k = KIND_OPER0 + 5'd4;
			8'h2F:   k = KIND_OPER0 + 5'd6;
			8'h25:   k = KIND_OPER0 + 5'd8;
			8'h3D:   k = KIND_OPER0 + 5'd10;
			8'h21:   k = KIND_OPER0 + 5'd12;
			8'h3C:   k = KIND_OPER0 + 5'd14;
			8'h3E:   k = KIND_OPER0 + 5'd16;
			default: k = 5'd0;
		endcase
		return k;
	endfunction

	function automatic logic [LB-1:0] sat_inc(input logic [LB-1:0] n);
		return (n == {LB{1'b1}}) ? n : n + 1'b1;
	endfunction

	function automatic stt_result_t make_res(input logic [4:0] kind,
			input logic [PB-1:0] pos, input logic [PB-1:0] line,
			input logic [PB-1:0] col, input logic [LB-1:0] len,
			input logic [63:0] val, input logic bad);
		stt_result_t r;
		r.kind     = kind;
		r.position = 32'(pos);
		r.line     = 32'(line);
		r.column   = 32'(col);
		r.length   = 16'(len);
		r.value    = val;
		r.bad      = bad;
		r.last     = 1'b0;
		return r;
	endfunction

	mode_t         mode_q, mode_n, m;
	logic [4:0]    pend_q, pend_n;
	logic [1:0]    base_q, base_n;
	logic [63:0]   acc_q, acc_n, acc_scaled;
	logic [PB-1:0] start_pos_q, start_line_q, start_col_q;
	logic [PB-1:0] start_pos_n, start_line_n, start_col_n;
	logic [LB-1:0] cnt_q, cnt_n;
	logic          err_q, err_n;
	logic [PB-1:0] pos_q, line_q, col_q;
	logic [PB-1:0] pos_n, line_n, col_n;
	logic          ended_q, ended_n;
	logic [7:0]    c;
	logic [4:0]    dv, radix, pk, ok;
	logic          done, consume, mark;
	logic          tok_v, idl_v;
	stt_result_t   tok, idl;

	// Scale the accumulator by the current base
	always_comb begin
		unique case (base_q)
			BASE_HEX: begin
				acc_scaled = {acc_q[59:0], 4'b0000};
				radix      = 5'd16;
			end
			BASE_BIN: begin
				acc_scaled = {acc_q[62:0], 1'b0};
				radix      = 5'd2;
			end
			default: begin
				acc_scaled = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0};
				radix      = 5'd10;
			end
		endcase
	end

	// Decide the results and the next state for one byte
	always_comb begin
		c     = eos_in ? CH_NUL : byte_in;
		dv    = digit_value(c);
		pk    = punct_kind(c);
		ok    = oper_kind(c);
		m     = mode_q;
		pend_n = pend_q;
		base_n = base_q;
		acc_n  = acc_q;
		cnt_n  = cnt_q;
		err_n  = err_q;
		ended_n = ended_q;
		done    = 1'b0;
		consume = 1'b0;
		mark    = 1'b0;
		tok_v   = 1'b0;
		idl_v   = 1'b0;
		tok     = '0;
		idl     = '0;
		if (!ended_q) begin
			// Close or extend an operator
			if (m == M_OPER) begin
				if (c == CH_EQ) begin
					cnt_n   = sat_inc(cnt_q);
					tok_v   = 1'b1;
					tok     = make_res(pend_q + 5'd1, start_pos_q, start_line_q,
						start_col_q, sat_inc(cnt_q), 64'd0, 1'b0);
					consume = 1'b1;
					done    = 1'b1;
				end else begin
					tok_v = 1'b1;
					tok   = make_res(pend_q, start_pos_q, start_line_q, start_col_q,
						cnt_q, 64'd0, 1'b0);
				end
				m = M_IDLE;
			end
			// Take a base prefix after a leading zero
			if (!done && m == M_ZERO) begin
				m = M_NUM;
				if (c == CH_X_LO || c == CH_X_UP || c == CH_B_LO || c == CH_B_UP) begin
					base_n  = (c == CH_X_LO || c == CH_X_UP) ? BASE_HEX : BASE_BIN;
					cnt_n   = sat_inc(cnt_q);
					consume = 1'b1;
					done    = 1'b1;
				end
			end
			// Accumulate digits, skip separators, or close the integer
			if (!done && m == M_NUM) begin
				if (c == CH_UNDER) begin
					cnt_n   = sat_inc(cnt_q);
					consume = 1'b1;
					done    = 1'b1;
				end else if (dv != 5'd16) begin
					acc_n   = acc_scaled + 64'(dv);
					if (dv >= radix) err_n = 1'b1;
					cnt_n   = sat_inc(cnt_q);
					consume = 1'b1;
					done    = 1'b1;
				end else begin
					tok_v = 1'b1;
					tok   = make_res(KIND_INT, start_pos_q, start_line_q, start_col_q,
						cnt_q, acc_q, err_q);
					m     = M_IDLE;
				end
			end
			// Extend or close an identifier
			if (!done && m == M_IDENT) begin
				if (is_letter(c) || is_digit(c)) begin
					cnt_n   = sat_inc(cnt_q);
					consume = 1'b1;
					done    = 1'b1;
				end else begin
					tok_v = 1'b1;
					tok   = make_res(KIND_IDENT, start_pos_q, start_line_q, start_col_q,
						cnt_q, 64'd0, 1'b0);
					m     = M_IDLE;
				end
			end
			// Byte seen from the idle mode
			if (!done) begin
				m = M_IDLE;
				if (c == CH_NUL) begin
					ended_n = 1'b1;
					idl_v   = 1'b1;
					idl     = make_res(KIND_EOF, pos_q, line_q, col_q, '0, 64'd0, 1'b0);
				end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
					consume = 1'b1;
				end else if (pk != 5'd0) begin
					idl_v   = 1'b1;
					idl     = make_res(pk, pos_q, line_q, col_q, LB'(1), 64'd0, 1'b0);
					consume = 1'b1;
				end else if (ok != 5'd0) begin
					mark    = 1'b1;
					pend_n  = ok;
					m       = M_OPER;
					consume = 1'b1;
				end else if (is_digit(c)) begin
					mark    = 1'b1;
					acc_n   = 64'(c - CH_ZERO);
					base_n  = BASE_DEC;
					err_n   = 1'b0;
					m       = (c == CH_ZERO) ? M_ZERO : M_NUM;
					consume = 1'b1;
				end else if (is_letter(c)) begin
					mark    = 1'b1;
					m       = M_IDENT;
					consume = 1'b1;
				end else begin
					idl_v   = 1'b1;
					idl     = make_res(KIND_UNKNOWN, pos_q, line_q, col_q, LB'(1),
						64'(c), 1'b0);
					consume = 1'b1;
				end
			end
			if (mark) cnt_n = LB'(1);
		end
		mode_n = m;
	end

	// Advance the position counters and latch the token start
	always_comb begin
		pos_n  = pos_q;
		line_n = line_q;
		col_n  = col_q;
		if (consume) begin
			pos_n = pos_q + 1'b1;
			if (c == CH_LF) begin
				line_n = line_q + 1'b1;
				col_n  = PB'(1);
			end else begin
				col_n = col_q + 1'b1;
			end
		end
		start_pos_n  = mark ? pos_q  : start_pos_q;
		start_line_n = mark ? line_q : start_line_q;
		start_col_n  = mark ? col_q  : start_col_q;
	end

	// Order the results and mark the last one
	always_comb begin
		res0      = tok_v ? tok : idl;
		res0.last = !(tok_v && idl_v);
		res1      = idl;
		res1.last = 1'b1;
		status.ended = ended_q;
		status.count = {1'b0, tok_v} + {1'b0, idl_v};
	end

	// Hold the scanner state; update on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			pend_q       <= '0;
			base_q       <= BASE_DEC;
			acc_q        <= '0;
			start_pos_q  <= '0;
			start_line_q <= PB'(1);
			start_col_q  <= PB'(1);
			cnt_q        <= '0;
			err_q        <= 1'b0;
			pos_q        <= '0;
			line_q       <= PB'(1);
			col_q        <= PB'(1);
			ended_q      <= 1'b0;
		end else if (fire) begin
			mode_q       <= mode_n;
			pend_q       <= pend_n;
			base_q       <= base_n;
			acc_q        <= acc_n;
			start_pos_q  <= start_pos_n;
			start_line_q <= start_line_n;
			start_col_q  <= start_col_n;
			cnt_q        <= cnt_n;
			err_q        <= err_n;
			pos_q        <= pos_n;
			line_q       <= line_n;
			col_q        <= col_n;
			ended_q      <= ended_n;
		end
	end

endmodule

### rtl/stt_queue.sv
// Result queue of the tokenizer: takes up to two results a cycle, gives one.
module stt_queue
	import stt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  push_count,
	input  stt_result_t push0,
	input  stt_result_t push1,
	input  logic        pop,
	output stt_result_t head,
	output logic [$clog2(STT_QUEUE_DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(STT_QUEUE_DEPTH);
	localparam int CW = $clog2(STT_QUEUE_DEPTH + 1);

	stt_result_t   entry_q [STT_QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign head  = entry_q[rd_q];
	assign count = count_q;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) entry_q[wr_q] <= push0;
		if (push_count == 2'd2) entry_q[PW'(wr_q + 1'b1)] <= push1;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push_count);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + CW'(push_count) - CW'(pop);
		end
	end

endmodule

### rtl/source_text_tokenizer.sv
// Top level of the source text tokenizer: input register, scanner, result queue.
//
//  channel | dir | payload
//  s_*     | in  | tdata[7:0] source_byte, tuser[0] end_of_source
//  m_*     | out | tuser[4:0] token_kind, tdata per port comment, tlast last_of_run
//
// One byte per cycle is taken; the scanner processes the byte held in the input
// register and writes its zero, one or two results into a four-entry queue. A
// byte is processed when the queue holds two results or fewer, so bytes giving
// two results are paced by the one-per-cycle output port. Reset clears all scanner
// state and empties the queue; output stalls back up into the input register and
// then into s_tready.
module source_text_tokenizer
	import stt_pkg::*;
#(
	parameter int POSITION_BITS = STT_DEFAULT_POSITION_BITS,
	parameter int LENGTH_BITS   = STT_DEFAULT_LENGTH_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] source_byte
	input  logic [0:0]   s_tuser,  // [0] end_of_source
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] start_position, [63:32] start_line, [95:64] start_column,
	// [111:96] token_length, [175:112] int_value, [176] bad_digit, [183:177] zero
	output logic [183:0] m_tdata,
	output logic [4:0]   m_tuser,  // [4:0] token_kind
	output logic         m_tlast
);

	localparam int CW = $clog2(STT_QUEUE_DEPTH + 1);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eos_s1;
	logic             proc;
	logic             pop;
	logic [1:0]       push_count;
	logic [CW-1:0]    fill;
	stt_result_t      res0, res1, head;
	stt_scan_status_t status;

	// Process the held byte when the queue has room for two results
	assign proc       = valid_s1 && (fill <= CW'(STT_QUEUE_DEPTH - 2));
	assign s_tready   = !valid_s1 || proc;
	assign push_count = proc ? status.count : 2'd0;
	assign pop        = m_tvalid && m_tready;

	// Hold the input byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tuser[0];
		end
	end

	stt_scan #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (proc),
		.byte_in(byte_s1),
		.eos_in (eos_s1),
		.res0   (res0),
		.res1   (res1),
		.status (status)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_count(push_count),
		.push0     (res0),
		.push1     (res1),
		.pop       (pop),
		.head      (head),
		.count     (fill)
	);

	// Drive the result port from the queue head
	assign m_tvalid = (fill != '0);
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {7'd0, head.bad, head.value, head.length, head.column,
		head.line, head.position};

	// Queue never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CW'(STT_QUEUE_DEPTH))
		else $error("result queue overfilled");

	// No result after end of stream
	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		status.ended |-> (status.count == 2'd0))
		else $error("result produced after end of stream");

	// A double result lands in the queue in full
	a_double_push: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && status.count == 2'd2) |=>
		(fill == $past(fill) + CW'(2) - CW'($past(pop))))
		else $error("double result not queued");

endmodule
